// File: hdl/assert_macros.svh
// Assertion macros used by the solver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion checked at each rising edge, disabled while reset is high.
`define BSS_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion checked at each rising edge, also during reset.
`define BSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/bss_pkg.sv
// Shared types and constants of the backtracking SAT solver.
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

   // Fixed field widths of the channels and registers.
   localparam int VC_W   = 7;
   localparam int CC_W   = 9;
   localparam int IDX_W  = 8;
   localparam int MASK_W = 64;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = CC_W;

   // Operation codes carried in req_tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SOLVE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_VARIABLE_COUNT = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_CLAUSE_COUNT   = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic row_write;   // store the clause row of the current request
      logic init;        // set up a new search
      logic scan_start;  // check all used clauses under the current assignment
      logic descend;     // move to the next level, value true
      logic flip;        // switch the current level to false
      logic pop;         // clear the current level and step back one level
      logic out_load;    // load the result register
      logic out_sat;     // result flag that goes with out_load
   } bss_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;   // clause scan finished this cycle
      logic scan_ok;     // every used clause can still be satisfied
      logic last_level;  // current level is the last variable
      logic no_vars;     // instance has no variables
      logic tried_bit;   // false branch of the current level already taken
      logic level_zero;  // current level is the first variable
      logic out_free;    // result register can take a new result
   } bss_sts_type;

endpackage

`default_nettype wire

// File: hdl/bss_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hdl/bss_datapath.sv
// Datapath of the solver: clause store, clause scan, search registers, result register.
`timescale 1ns / 1ps
`default_nettype none

module bss_datapath import bss_pkg::*; #(
   parameter int MAX_VARIABLES = 64,
   parameter int MAX_CLAUSES   = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bss_cmd_type       cmd,
   output bss_sts_type            sts,
   input  wire logic [IDX_W-1:0]  clause_index,
   input  wire logic [MASK_W-1:0] positive_mask,
   input  wire logic [MASK_W-1:0] negative_mask,
   input  wire logic [VC_W-1:0]   variable_count,
   input  wire logic [CC_W-1:0]   clause_count,
   input  wire logic              rsp_tready,
   output logic                   rsp_tvalid,
   output logic                   rsp_tuser,
   output logic [MASK_W-1:0]      rsp_tdata
);

   localparam int NV    = MAX_VARIABLES;
   localparam int LW    = (NV > 1) ? $clog2(NV) : 1;
   localparam int AW    = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
   localparam logic [16:0]     RowLimit = 17'(MAX_CLAUSES);
   localparam logic [VC_W-1:0] VarLimit = VC_W'(NV);

   // Search registers.
   logic [NV-1:0]   values_ff, values_in;
   logic [NV-1:0]   tried_ff, tried_in;
   logic [LW-1:0]   lvl_ff, lvl_in;
   logic [NV-1:0]   active_ff, active_in;
   logic [VC_W-1:0] nvars_ff, nvars_in;
   logic            no_vars_ff, no_vars_in;
   logic [CC_W-1:0] clauses_ff, clauses_in;

   // Clause scan registers.
   logic            busy_ff, busy_in;
   logic [CC_W-1:0] cnt_ff, cnt_in;
   logic            pend_ff, pend_in;
   logic            last_ff, last_in;
   logic            done_ff, done_in;
   logic            ok_ff, ok_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_sat_ff, rsp_sat_in;
   logic [MASK_W-1:0] rsp_data_ff, rsp_data_in;

   logic [NV-1:0]   lvl_bit;
   logic [NV-1:0]   assigned;
   logic [NV-1:0]   vals;
   logic [NV-1:0]   free_vars;
   logic [NV-1:0]   hit;
   logic [2*NV-1:0] row_data;
   logic [NV-1:0]   row_pos;
   logic [NV-1:0]   row_neg;
   logic            row_ok;
   logic            is_last;
   logic            miss;
   logic [16:0]     idx_wide;
   logic [16:0]     cnt_wide;
   logic [16:0]     cc_wide;
   logic [VC_W-1:0] n_sat;

   // Clause store: positive mask in the low half, negative mask in the high half.
   assign idx_wide = 17'(clause_index);
   assign cnt_wide = 17'(cnt_ff);
   assign row_ok   = idx_wide < RowLimit;

   bss_ram #(
      .WIDTH (2 * NV),
      .DEPTH (MAX_CLAUSES)
   ) u_rows (
      .clock   (clock),
      .wr_en   (cmd.row_write && row_ok),
      .wr_addr (idx_wide[AW-1:0]),
      .wr_data ({negative_mask[NV-1:0], positive_mask[NV-1:0]}),
      .rd_en   (busy_ff),
      .rd_addr (cnt_wide[AW-1:0]),
      .rd_data (row_data)
   );

   assign row_pos = row_data[NV-1:0];
   assign row_neg = row_data[2*NV-1:NV];

   // Masks of assigned and free variables at the current level.
   assign lvl_bit = NV'(1) << lvl_ff;

   always_comb begin
      for (int i = 0; i < NV; i++) begin
         assigned[i] = !no_vars_ff && (LW'(i) <= lvl_ff);
      end
   end

   assign vals      = values_ff & assigned;
   assign free_vars = active_ff & ~assigned;
   assign hit       = (row_pos & vals) | (row_neg & assigned & ~vals)
                    | ((row_pos | row_neg) & free_vars);

   // A clause with no live literal ends the scan at once.
   assign miss    = pend_ff && (hit == '0);
   assign is_last = (cnt_ff + CC_W'(1)) == clauses_ff;

   // Saturated instance size, taken at the start of a solve.
   assign cc_wide = 17'(clause_count);
   assign n_sat   = (variable_count > VarLimit) ? VarLimit : variable_count;

   always_comb begin
      clauses_in = clauses_ff;
      active_in  = active_ff;
      nvars_in   = nvars_ff;
      no_vars_in = no_vars_ff;
      values_in  = values_ff;
      tried_in   = tried_ff;
      lvl_in     = lvl_ff;
      if (cmd.init) begin
         clauses_in = (cc_wide > RowLimit) ? CC_W'(RowLimit) : clause_count;
         for (int i = 0; i < NV; i++) begin
            active_in[i] = VC_W'(i) < n_sat;
         end
         nvars_in   = n_sat;
         no_vars_in = (n_sat == '0);
         values_in  = NV'(n_sat != '0);
         tried_in   = '0;
         lvl_in     = '0;
      end else if (cmd.descend) begin
         lvl_in    = lvl_ff + LW'(1);
         values_in = values_ff | (lvl_bit << 1);
         tried_in  = tried_ff & ~(lvl_bit << 1);
      end else if (cmd.flip) begin
         tried_in  = tried_ff | lvl_bit;
         values_in = values_ff & ~lvl_bit;
      end else if (cmd.pop) begin
         tried_in  = tried_ff & ~lvl_bit;
         values_in = values_ff & ~lvl_bit;
         lvl_in    = lvl_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      clauses_ff <= clauses_in;
      active_ff  <= active_in;
      nvars_ff   <= nvars_in;
      no_vars_ff <= no_vars_in;
      values_ff  <= values_in;
      tried_ff   <= tried_in;
      lvl_ff     <= lvl_in;
   end

   // Clause scan: one row read per cycle, each row checked in the cycle after its read.
   always_comb begin
      if (cmd.scan_start) begin
         busy_in = (clauses_ff != '0);
         cnt_in  = '0;
         pend_in = 1'b0;
         last_in = 1'b0;
         done_in = (clauses_ff == '0);
         ok_in   = 1'b1;
      end else begin
         busy_in = busy_ff && !is_last && !miss;
         cnt_in  = busy_ff ? cnt_ff + CC_W'(1) : cnt_ff;
         pend_in = busy_ff && !miss;
         last_in = busy_ff && is_last;
         done_in = miss || (pend_ff && last_ff);
         ok_in   = !miss;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         last_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         last_ff <= last_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      ok_ff  <= ok_in;
   end

   // Result register; an unsatisfiable instance reports a zero assignment.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_sat_in   = cmd.out_sat;
         rsp_data_in  = cmd.out_sat ? MASK_W'(values_ff) : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sat_ff  <= rsp_sat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status toward the controller.
   always_comb begin
      sts.scan_done  = done_ff;
      sts.scan_ok    = ok_ff;
      sts.last_level = (VC_W'(lvl_ff) + VC_W'(1)) == nvars_ff;
      sts.no_vars    = no_vars_ff;
      sts.tried_bit  = tried_ff[lvl_ff];
      sts.level_zero = (lvl_ff == '0);
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

// File: hdl/bss_ctrl.sv
// Controller of the solver: request decode and the depth-first search sequence.
`timescale 1ns / 1ps
`default_nettype none

module bss_ctrl import bss_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_operation,
   output logic             req_tready,
   output bss_cmd_type      cmd,
   input  wire bss_sts_type sts
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_WAIT   = 3'd2;
   localparam logic [2:0] ST_BACK   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       sat_ff, sat_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Search sequence: check, then descend, flip or backtrack.
   always_comb begin
      state_in = state_ff;
      sat_in   = sat_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_WRITE) begin
                  cmd.row_write = 1'b1;
               end else begin
                  cmd.init = 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.scan_done) begin
               priority if (sts.no_vars) begin
                  sat_in   = sts.scan_ok;
                  state_in = ST_FINISH;
               end else if (!sts.scan_ok) begin
                  state_in = ST_BACK;
               end else if (sts.last_level) begin
                  sat_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  cmd.descend = 1'b1;
                  state_in    = ST_START;
               end
            end
         end
         ST_BACK: begin
            priority if (!sts.tried_bit) begin
               cmd.flip = 1'b1;
               state_in = ST_START;
            end else if (sts.level_zero) begin
               sat_in   = 1'b0;
               state_in = ST_FINISH;
            end else begin
               cmd.pop = 1'b1;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sat  = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff <= sat_in;
   end

endmodule

`default_nettype wire

// File: hdl/backtracking_sat_solver_top.sv
// Top level of the backtracking SAT solver: ports, configuration registers, checks.
//
// Usage: load clause rows with write requests (req_tuser = 0), one row per
// transfer, then send a solve request (req_tuser = 1).
// csr_* sets variable_count (index 0) and clause_count (index 1); the user is
// to do so only while idle, as the block itself does not enforce it.
// A write produces no result; a solve produces one transfer on rsp_*:
// rsp_tuser is the satisfiable flag, rsp_tdata the assignment (zero when
// unsatisfiable). A solve runs one clause scan per tried assignment (one
// clause store read per cycle, stopping at the first dead clause) and one
// backtrack step per level given up; the block takes no new request until
// the solve result is in the output register.
// Reset clears the controller, scan and output valid state; the clause store
// needs no clearing. A stalled receiver holds the result in the output
// register while new write requests are still taken; a finished solve waits
// until that register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module backtracking_sat_solver_top import bss_pkg::*; #(
   parameter int MAX_VARIABLES = 64,
   parameter int MAX_CLAUSES   = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  req_tuser,   // operation
   input  wire logic [135:0]          req_tdata,   // clause_index, positive_mask, negative_mask
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tuser,   // satisfiable
   output logic [MASK_W-1:0]          rsp_tdata,   // assignment
   // Configuration port.
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [VC_W-1:0] variable_count_ff;
   logic [CC_W-1:0] clause_count_ff;
   bss_cmd_type     cmd;
   bss_sts_type     sts;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         variable_count_ff <= '0;
         clause_count_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_VARIABLE_COUNT: variable_count_ff <= csr_wdata[VC_W-1:0];
            REG_CLAUSE_COUNT:   clause_count_ff   <= csr_wdata;
            default:            clause_count_ff   <= clause_count_ff;
         endcase
      end
   end

   bss_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_operation (req_tuser),
      .req_tready    (req_tready),
      .cmd           (cmd),
      .sts           (sts)
   );

   bss_datapath #(
      .MAX_VARIABLES (MAX_VARIABLES),
      .MAX_CLAUSES   (MAX_CLAUSES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .clause_index   (req_tdata[IDX_W-1:0]),
      .positive_mask  (req_tdata[IDX_W+MASK_W-1:IDX_W]),
      .negative_mask  (req_tdata[IDX_W+2*MASK_W-1:IDX_W+MASK_W]),
      .variable_count (variable_count_ff),
      .clause_count   (clause_count_ff),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tuser      (rsp_tuser),
      .rsp_tdata      (rsp_tdata)
   );

   // A new result never overwrites one that has not been transferred.
   `BSS_ASSERT_RST(a_load_free, clock, reset, cmd.out_load |-> sts.out_free, "result overwritten")
   // An unsatisfiable result carries a zero assignment.
   `BSS_ASSERT_RST(a_unsat_zero, clock, reset, (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0), "nonzero assignment when unsatisfiable")
   // A solve holds the request side until it has finished.
   `BSS_ASSERT_RST(a_solve_busy, clock, reset, (req_tvalid && req_tready && req_tuser == OP_SOLVE) |=> !req_tready, "request taken during solve")
   // Only one search command is issued in a cycle.
   `BSS_ASSERT_ALWAYS(a_one_cmd, clock, $onehot0({cmd.init, cmd.scan_start, cmd.descend, cmd.flip, cmd.pop, cmd.out_load}), "conflicting commands")

endmodule

`default_nettype wire

// File: test/tb_backtracking_sat_solver_top.sv
// Self-checking testbench for the backtracking SAT solver top level.
`timescale 1ns / 1ps

module tb_backtracking_sat_solver_top;
   import bss_pkg::*;

   // Roughly how many request transfers the random part sends.
   localparam int unsigned ITEM_TARGET  = 1000;
   // Largest estimated solve time that the clause generator lets through.
   localparam int unsigned SOLVE_BUDGET = 20000;
   // Several times the slowest correct run: every request a solve at the budget,
   // every result behind the longest receiver stall, every request behind a long gap.
   localparam int unsigned CYCLE_LIMIT  = 100_000_000;
   localparam int STYLE_SHORT = 0;
   localparam int STYLE_DENSE = 1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic                  req_tuser;    // operation
   logic [135:0]          req_tdata;    // clause_index, positive_mask, negative_mask
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  rsp_tuser;    // satisfiable
   logic [MASK_W-1:0]     rsp_tdata;    // assignment
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   backtracking_sat_solver_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // One solve outcome: the flag and the assignment.
   typedef struct packed {
      logic              sat;
      logic [MASK_W-1:0] asg;
   } verdict_t;

   // Clause store copy, register copy and the queue of solve outcomes to come.
   class sat_scoreboard;
      logic [63:0] pos_rows [256];
      logic [63:0] neg_rows [256];
      int unsigned var_count;
      int unsigned clause_count;
      verdict_t    expected_q [$];
      int unsigned mismatches;
      int unsigned row_writes;
      int unsigned solves;
      int unsigned sat_seen;

      function new();
         foreach (pos_rows[i]) begin
            pos_rows[i] = '0;
            neg_rows[i] = '0;
         end
         var_count    = 0;
         clause_count = 0;
         mismatches   = 0;
         row_writes   = 0;
         solves       = 0;
         sat_seen     = 0;
      endfunction

      static function logic [63:0] low_mask(int unsigned n);
         if (n >= 64)
            return '1;
         return (64'd1 << n) - 64'd1;
      endfunction

      function void set_register(logic [CSR_ADDR_W-1:0] addr, int unsigned value);
         if (addr == REG_VARIABLE_COUNT)
            var_count = value & 'h7F;
         else
            clause_count = value & 'h1FF;
      endfunction

      function void store_row(int unsigned idx, logic [63:0] p, logic [63:0] q);
         pos_rows[idx] = p;
         neg_rows[idx] = q;
      endfunction

      // A clause stays alive while one of its literals is true or still unassigned.
      function bit clauses_alive(logic [63:0] vals, logic [63:0] assigned,
                                 logic [63:0] active, int unsigned used);
         logic [63:0] unset;
         logic [63:0] val_set;
         logic [63:0] hit;
         unset   = active & ~assigned;
         val_set = vals & assigned;
         for (int unsigned c = 0; c < used; c++) begin
            hit = (pos_rows[c] & val_set) | (neg_rows[c] & assigned & ~val_set)
                | ((pos_rows[c] | neg_rows[c]) & unset);
            if (hit == '0)
               return 0;
         end
         return 1;
      endfunction

      // Depth-first search in variable order, true before false.
      function void find_assignment(output verdict_t res, output int unsigned tries);
         int unsigned n;
         int unsigned used;
         int unsigned lvl;
         logic [63:0] active;
         logic [63:0] vals;
         logic [63:0] tried;
         bit          found;
         bit          searching;
         bit          unwinding;
         n      = (var_count > 64) ? 64 : var_count;
         used   = (clause_count > 256) ? 256 : clause_count;
         active = low_mask(n);
         lvl    = 0;
         tried  = '0;
         found  = 0;
         tries  = 1;
         if (n == 0) begin
            vals  = '0;
            found = clauses_alive(vals, '0, '0, used);
         end else begin
            vals      = 64'd1;
            searching = 1;
            tries     = 0;
            while (searching) begin
               tries++;
               if (clauses_alive(vals, low_mask(lvl + 1), active, used)) begin
                  if (lvl + 1 == n) begin
                     found     = 1;
                     searching = 0;
                  end else begin
                     lvl++;
                     vals[lvl]  = 1'b1;
                     tried[lvl] = 1'b0;
                  end
               end else begin
                  // Step back to the deepest level whose false branch is still open.
                  unwinding = 1;
                  while (unwinding) begin
                     vals[lvl] = 1'b0;
                     if (!tried[lvl]) begin
                        tried[lvl] = 1'b1;
                        unwinding  = 0;
                     end else begin
                        tried[lvl] = 1'b0;
                        if (lvl == 0) begin
                           unwinding = 0;
                           searching = 0;
                        end else begin
                           lvl--;
                        end
                     end
                  end
               end
            end
         end
         res.sat = found;
         res.asg = found ? vals : '0;
      endfunction

      // Rough solve time: one clause scan per tried assignment plus overhead.
      function int unsigned search_cycles();
         verdict_t    res;
         int unsigned tries;
         int unsigned used;
         used = (clause_count > 256) ? 256 : clause_count;
         find_assignment(res, tries);
         return tries * (used + 4) + 70;
      endfunction

      function void note_request(logic op, int unsigned idx, logic [63:0] p, logic [63:0] q);
         verdict_t    res;
         int unsigned tries;
         if (op == OP_WRITE) begin
            store_row(idx, p, q);
            row_writes++;
         end else begin
            find_assignment(res, tries);
            expected_q.push_back(res);
            solves++;
            if (res.sat)
               sat_seen++;
         end
      endfunction

      function void check_response(logic sat, logic [63:0] asg);
         verdict_t want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: result with no solve pending, satisfiable %0b assignment %h",
                        sat, asg);
            return;
         end
         want = expected_q.pop_front();
         if (sat !== want.sat || asg !== want.asg) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: satisfiable exp %0b got %0b, assignment exp %h got %h",
                        want.sat, sat, want.asg, asg);
         end
      endfunction
   endclass

   sat_scoreboard sb   = new();
   sat_scoreboard plan = new();   // tracks rows ahead of sending, to bound search time

   int unsigned items_sent;
   int unsigned settings_done;
   int unsigned cycle_count;
   bit          steady_req;
   int unsigned batch_idx [$];
   logic [63:0] batch_pos [$];
   logic [63:0] batch_neg [$];

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Check every result transfer against the oldest pending solve.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata);
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly no gap, some short ones and a few long ones.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void make_clause(input int unsigned n, input int style,
                                       output logic [63:0] p, output logic [63:0] q);
      int unsigned k;
      int unsigned v;
      p = '0;
      q = '0;
      if (style == STYLE_DENSE) begin
         p = rand64();
         q = rand64();
      end else begin
         if (n > 0) begin
            k = $urandom_range(1, 3);
            repeat (k) begin
               v = $urandom_range(0, n - 1);
               if ($urandom_range(0, 1))
                  p[v] = 1'b1;
               else
                  q[v] = 1'b1;
            end
         end
         // Literals on variables beyond the count must be ignored by the search.
         if ($urandom_range(0, 3) == 0) begin
            p |= rand64() & ~sat_scoreboard::low_mask(n);
            q |= rand64() & ~sat_scoreboard::low_mask(n);
         end
         // Now and then an empty clause, which makes the instance unsatisfiable if its row is in use.
         if ($urandom_range(0, 49) == 0) begin
            p = '0;
            q = '0;
         end
      end
   endfunction

   // Result receiver stalls: calm stretches alternate with random stalls.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(50, 300)) @(posedge clock);
         end else begin
            repeat ($urandom_range(20, 60)) begin
               int unsigned g;
               g = gap_len();
               if (g > 0) begin
                  rsp_tready <= 1'b0;
                  repeat (g) @(posedge clock);
               end
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 4)) @(posedge clock);
            end
         end
      end
   end

   // Drive one request and hold it until the transfer; tvalid stays high.
   task automatic push_request(input logic op, input logic [7:0] idx,
                               input logic [63:0] p, input logic [63:0] q);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {q, p, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, idx, p, q);
      items_sent++;
   endtask

   task automatic pause_after();
      int unsigned g;
      g = steady_req ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic write_row(input logic [7:0] idx, input logic [63:0] p, input logic [63:0] q);
      plan.store_row(idx, p, q);
      push_request(OP_WRITE, idx, p, q);
      pause_after();
   endtask

   // The row index and masks of a solve are don't-care, so they carry noise.
   task automatic solve_now();
      push_request(OP_SOLVE, 8'($urandom), rand64(), rand64());
      pause_after();
   endtask

   // Wait until no solve is outstanding and the last row write has settled.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input int unsigned n, input int unsigned cc);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= REG_VARIABLE_COUNT;
      csr_wdata <= CSR_DATA_W'(n);
      @(posedge clock);
      csr_addr  <= REG_CLAUSE_COUNT;
      csr_wdata <= CSR_DATA_W'(cc);
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_register(REG_VARIABLE_COUNT, n);
      sb.set_register(REG_CLAUSE_COUNT, cc);
      plan.set_register(REG_VARIABLE_COUNT, n);
      plan.set_register(REG_CLAUSE_COUNT, cc);
      settings_done++;
   endtask

   // Fill the rows named in batch_idx, redrawing them while the search would be
   // too slow, then send the writes and one solve.
   task automatic plan_and_send(input int unsigned n, input int style, input int unsigned used);
      logic [63:0] p;
      logic [63:0] q;
      bit          ok;
      ok = 0;
      for (int tries = 0; tries < 8 && !ok; tries++) begin
         batch_pos.delete();
         batch_neg.delete();
         foreach (batch_idx[i]) begin
            make_clause(n, style, p, q);
            batch_pos.push_back(p);
            batch_neg.push_back(q);
            plan.store_row(batch_idx[i], p, q);
         end
         ok = plan.search_cycles() <= SOLVE_BUDGET;
      end
      // Fall back to clauses that the all-true assignment satisfies at once.
      if (!ok) begin
         for (int unsigned i = 0; i < used; i++) begin
            batch_idx.push_back(i);
            batch_pos.push_back('1);
            batch_neg.push_back('0);
            plan.store_row(i, '1, '0);
         end
      end
      foreach (batch_idx[i])
         write_row(batch_idx[i], batch_pos[i], batch_neg[i]);
      solve_now();
      batch_idx.delete();
   endtask

   // One register setting: fresh rows, then a few rounds of edits and solves.
   task automatic run_random_phase();
      int unsigned r;
      int unsigned n;
      int unsigned cc;
      int unsigned neff;
      int unsigned used;
      int          style;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: n = 0;
            1: n = 1;
            2: n = 64;
            default: n = 127;
         endcase
         cc    = $urandom_range(0, 6);
         style = STYLE_DENSE;
      end else if (r <= 2) begin
         n     = $urandom_range(11, 64);
         cc    = $urandom_range(1, 32);
         style = STYLE_DENSE;
      end else begin
         n     = $urandom_range(1, 10);
         cc    = $urandom_range(0, 24);
         style = STYLE_SHORT;
      end
      set_config(n, cc);
      steady_req = ($urandom_range(0, 4) == 0);
      neff = (n > 64) ? 64 : n;
      used = (cc > 256) ? 256 : cc;
      for (int unsigned i = 0; i < used; i++)
         batch_idx.push_back(i);
      plan_and_send(neff, style, used);
      repeat ($urandom_range(2, 6)) begin
         repeat ($urandom_range(0, 3)) begin
            if (used > 0 && $urandom_range(0, 3) != 0)
               batch_idx.push_back($urandom_range(0, used - 1));
            else
               batch_idx.push_back($urandom_range(0, 255));
         end
         plan_and_send(neff, style, used);
      end
   endtask

   // Main sequence: reset, directed cases, random phases, drain and verdict.
   initial begin
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tuser     <= OP_WRITE;
      req_tdata     <= '0;
      csr_we        <= 1'b0;
      csr_addr      <= REG_VARIABLE_COUNT;
      csr_wdata     <= '0;
      items_sent    = 0;
      settings_done = 0;
      steady_req    = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset values: no variables and no clauses, so the empty instance holds.
      solve_now();
      // No variables but one clause row in use: unsatisfiable.
      write_row(0, '0, '0);
      set_config(0, 1);
      solve_now();
      // Empty clause with variables: the search exhausts every branch.
      set_config(3, 1);
      solve_now();
      // Literals only on variables beyond the count act as an empty clause.
      write_row(0, 64'h8000_0000_0000_0020, '0);
      solve_now();
      // Unique solution x0 = 0, x1 = 1, x2 = 0, with ignored high literals.
      write_row(0, 64'h0000_0000_0000_00F0, 64'h1);
      write_row(1, 64'h2, '0);
      write_row(2, '0, 64'h4);
      set_config(3, 3);
      solve_now();
      // All four two-literal clauses over two variables: unsatisfiable.
      write_row(0, 64'h3, '0);
      write_row(1, 64'h1, 64'h2);
      write_row(2, 64'h2, 64'h1);
      write_row(3, '0, 64'h3);
      set_config(2, 4);
      solve_now();
      // Full width: a tautology and a clause forcing the top variable false.
      write_row(0, '1, '1);
      write_row(1, '0, 64'h8000_0000_0000_0000);
      write_row(255, '1, '0);
      set_config(64, 2);
      solve_now();
      // A variable count above the maximum saturates to it.
      set_config(127, 2);
      solve_now();

      // Whole clause store in use, then a clause count that saturates.
      set_config(64, 256);
      for (int unsigned i = 0; i < 256; i++)
         batch_idx.push_back(i);
      plan_and_send(64, STYLE_DENSE, 256);
      set_config(127, 511);
      batch_idx.push_back($urandom_range(0, 255));
      plan_and_send(64, STYLE_DENSE, 256);

      while (items_sent < ITEM_TARGET)
         run_random_phase();

      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("run covered %0d row writes and %0d solves (%0d satisfiable) over %0d settings",
               sb.row_writes, sb.solves, sb.sat_seen, settings_done);
      $display("result mismatches: %0d, results still missing: %0d",
               sb.mismatches, sb.expected_q.size());
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
